@@ hdl/pva_pkg.sv @@
// Shared types and constants for the PageRank vertex apply core.
// Used by pva_front, pva_queue, pva_back and pagerank_vertex_apply_core.

package pva_pkg;

   // Data and register widths
   localparam int DATA_W      = 32;
   localparam int DAMP_W      = 17;
   localparam int DAMP_FRAC   = 16;
   localparam int CSR_IDX_W   = 1;

   localparam logic [DAMP_W-1:0] ONE_Q016     = 17'h10000;
   localparam logic [DAMP_W-1:0] DAMP_RESET   = 17'd55706;
   localparam logic [DATA_W-1:0] THRESH_RESET = 32'd7;
   localparam logic [DATA_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

   localparam int FRAC_BITS_DEFAULT = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DAMPING   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 1'b1;

   // Commands
   localparam logic CMD_INIT  = 1'b0;
   localparam logic CMD_APPLY = 1'b1;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   // Divider sizing: dividend is damping*x with the Q1.16 fraction bits dropped
   localparam int PROD_W     = DAMP_W + DATA_W;
   localparam int DVD_W      = PROD_W - DAMP_FRAC;
   localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

   // One classified vertex word handed from front to back
   typedef struct packed {
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] degree;
      logic [DATA_W-1:0] score;
      logic [DATA_W-1:0] sum;
      logic [DATA_W-1:0] count;
      logic              active;
      logic              last;
      logic              do_push;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ hdl/pva_front.sv @@
// Front end: accepts vertex words, classifies them and keeps the pass count.
// Depends on pva_pkg; feeds pva_queue.

module pva_front #(
   parameter int FRAC_BITS = pva_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [pva_pkg::DATA_W-1:0]     req_vertex_delta,
   input  logic [pva_pkg::DATA_W-1:0]     req_vertex_score,
   input  logic [pva_pkg::DATA_W-1:0]     req_old_update_sum,
   input  logic [pva_pkg::DATA_W-1:0]     req_out_degree,
   input  logic                           req_last_vertex,
   input  logic [pva_pkg::DAMP_W-1:0]     damping_eff,
   input  logic [pva_pkg::DATA_W-1:0]     threshold,
   input  pva_pkg::queue_status_type      q_status,
   output logic                           q_push,
   output pva_pkg::work_type              q_entry
);

   localparam int SHL = (FRAC_BITS >= pva_pkg::DAMP_FRAC) ? FRAC_BITS - pva_pkg::DAMP_FRAC : 0;
   localparam int SHR = (FRAC_BITS <  pva_pkg::DAMP_FRAC) ? pva_pkg::DAMP_FRAC - FRAC_BITS : 0;

   logic [pva_pkg::DATA_W-1:0] count_ff, count_in;
   logic [pva_pkg::DATA_W-1:0] residual;
   logic [pva_pkg::DATA_W-1:0] count_now;
   logic [pva_pkg::DATA_W:0]   score_sum;
   logic                       hit;

   // Stall while the queue has no room
   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

   // Initial residual (1 - damping) moved to FRAC_BITS fraction bits
   always_comb begin
      residual = {{(pva_pkg::DATA_W-pva_pkg::DAMP_W){1'b0}},
                  pva_pkg::ONE_Q016 - damping_eff};
      residual = (residual << SHL) >> SHR;
   end

   // Classify the word
   always_comb begin
      hit       = (req_command == pva_pkg::CMD_APPLY) && (req_vertex_delta > threshold);
      score_sum = {1'b0, req_vertex_score} + {1'b0, req_vertex_delta};
      count_now = count_ff;
      if (hit && count_ff != pva_pkg::COUNT_MAX) begin
         count_now = count_ff + 1'b1;
      end

      q_entry.degree = req_out_degree;
      q_entry.count  = count_now;
      q_entry.last   = req_last_vertex;
      if (req_command == pva_pkg::CMD_INIT) begin
         q_entry.x      = residual;
         q_entry.score  = residual;
         q_entry.sum    = '0;
         q_entry.active = 1'b1;
      end else if (hit) begin
         q_entry.x      = req_vertex_delta;
         q_entry.score  = score_sum[pva_pkg::DATA_W] ? pva_pkg::COUNT_MAX
                                                     : score_sum[pva_pkg::DATA_W-1:0];
         q_entry.sum    = req_vertex_delta;
         q_entry.active = 1'b1;
      end else begin
         q_entry.x      = '0;
         q_entry.score  = req_vertex_score;
         q_entry.sum    = req_old_update_sum;
         q_entry.active = 1'b0;
      end
      q_entry.do_push = q_entry.active && (req_out_degree != '0);
   end

   // Advance the pass count, restart it after the last vertex
   always_comb begin
      count_in = count_ff;
      if (q_push) begin
         count_in = req_last_vertex ? '0 : count_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

@@ hdl/pva_queue.sv @@
// Short FIFO of classified vertex words between front and back.
// Depends on pva_pkg.

module pva_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  pva_pkg::work_type         push_entry,
   input  logic                      pop,
   output pva_pkg::work_type         head_entry,
   output pva_pkg::queue_status_type status
);

   pva_pkg::work_type                mem_ff [pva_pkg::QUEUE_DEPTH];
   logic [pva_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [pva_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [pva_pkg::QFILL_W-1:0]      fill_ff, fill_in;
   logic                             do_push, do_pop;

   assign status.full  = (fill_ff == pva_pkg::QFILL_W'(pva_pkg::QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign head_entry   = mem_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hdl/pva_back.sv @@
// Back end: multiplies by damping, divides by out-degree one bit a cycle,
// and holds the result word in the output register. Depends on pva_pkg.

module pva_back (
   input  logic                        clock,
   input  logic                        reset,
   input  pva_pkg::queue_status_type   q_status,
   input  pva_pkg::work_type           q_head,
   output logic                        q_pop,
   input  logic [pva_pkg::DAMP_W-1:0]  damping_eff,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pva_pkg::DATA_W-1:0]  rsp_new_score,
   output logic [pva_pkg::DATA_W-1:0]  rsp_push_value,
   output logic [pva_pkg::DATA_W-1:0]  rsp_new_update_sum,
   output logic                        rsp_vertex_active,
   output logic [pva_pkg::DATA_W-1:0]  rsp_update_count,
   output logic                        rsp_pass_done
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]                      state_ff, state_in;
   pva_pkg::work_type               ent_ff, ent_in;
   logic [pva_pkg::DVD_W-1:0]       dvd_ff, dvd_in;
   logic [pva_pkg::DATA_W-1:0]      rem_ff, rem_in;
   logic [pva_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [pva_pkg::PROD_W-1:0]      prod;
   logic [pva_pkg::DATA_W:0]        trial;
   logic [pva_pkg::DATA_W:0]        diff;
   logic                            qbit;
   logic                            out_free;
   logic                            load_out;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pva_pkg::DATA_W-1:0]      score_ff, push_ff, sum_ff, count_ff;
   logic                            active_ff, done_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign prod     = pva_pkg::PROD_W'(damping_eff) * pva_pkg::PROD_W'(ent_ff.x);

   // One restoring divide step
   always_comb begin
      trial = {rem_ff, dvd_ff[pva_pkg::DVD_W-1]};
      diff  = trial - {1'b0, ent_ff.degree};
      qbit  = (trial >= {1'b0, ent_ff.degree});
   end

   // Sequence one word: take, multiply, divide, deliver; a word that pushes nothing goes from take to deliver
   always_comb begin
      state_in = state_ff;
      ent_in   = ent_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      q_pop    = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               ent_in   = q_head;
               dvd_in   = '0;
               state_in = q_head.do_push ? ST_MUL : ST_FIN;
            end
         end
         ST_MUL: begin
            dvd_in   = prod[pva_pkg::PROD_W-1:pva_pkg::DAMP_FRAC];
            rem_in   = '0;
            cnt_in   = pva_pkg::DIV_CNT_W'(pva_pkg::DVD_W);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = qbit ? diff[pva_pkg::DATA_W-1:0] : trial[pva_pkg::DATA_W-1:0];
            dvd_in = {dvd_ff[pva_pkg::DVD_W-2:0], qbit};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == pva_pkg::DIV_CNT_W'(1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (load_out) begin
         score_ff  <= ent_ff.score;
         push_ff   <= dvd_ff[pva_pkg::DATA_W-1:0];
         sum_ff    <= ent_ff.sum;
         active_ff <= ent_ff.active;
         count_ff  <= ent_ff.count;
         done_ff   <= ent_ff.last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_new_score      = score_ff;
   assign rsp_push_value     = push_ff;
   assign rsp_new_update_sum = sum_ff;
   assign rsp_vertex_active  = active_ff;
   assign rsp_update_count   = count_ff;
   assign rsp_pass_done      = done_ff;

endmodule

@@ hdl/pagerank_vertex_apply_core.sv @@
// PageRank vertex apply core: each request word is one vertex record and yields one
// response word. Apply and init words whose vertex is active and whose out-degree is
// non-zero go through take, multiply, 33 divide steps of the radix-2 out-degree divider
// and deliver in the back end; other words go from take to deliver. A two-word queue
// lets the front accept while the divider runs, and the output register lets the next
// word start while a response waits. Registers: damping (index 0, Q1.16, values above
// 1.0 act as 1.0) and threshold (index 1); write them only while the core is idle.
// Depends on pva_pkg, pva_front, pva_queue and pva_back.

module pagerank_vertex_apply_core #(
   parameter int FRAC_BITS = pva_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [pva_pkg::DATA_W-1:0]     req_vertex_delta,
   input  logic [pva_pkg::DATA_W-1:0]     req_vertex_score,
   input  logic [pva_pkg::DATA_W-1:0]     req_old_update_sum,
   input  logic [pva_pkg::DATA_W-1:0]     req_out_degree,
   input  logic                           req_last_vertex,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pva_pkg::DATA_W-1:0]     rsp_new_score,
   output logic [pva_pkg::DATA_W-1:0]     rsp_push_value,
   output logic [pva_pkg::DATA_W-1:0]     rsp_new_update_sum,
   output logic                           rsp_vertex_active,
   output logic [pva_pkg::DATA_W-1:0]     rsp_update_count,
   output logic                           rsp_pass_done,
   input  logic                           csr_write_enable,
   input  logic [pva_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pva_pkg::DATA_W-1:0]     csr_write_data
);

   logic [pva_pkg::DAMP_W-1:0]  damping_ff, damping_in;
   logic [pva_pkg::DATA_W-1:0]  threshold_ff, threshold_in;
   logic [pva_pkg::DAMP_W-1:0]  damping_eff;
   pva_pkg::queue_status_type   q_status;
   pva_pkg::work_type           q_entry;
   pva_pkg::work_type           q_head;
   logic                        q_push;
   logic                        q_pop;

   // Decode register writes
   always_comb begin
      damping_in   = damping_ff;
      threshold_in = threshold_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            pva_pkg::REG_DAMPING:   damping_in   = csr_write_data[pva_pkg::DAMP_W-1:0];
            pva_pkg::REG_THRESHOLD: threshold_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff   <= pva_pkg::DAMP_RESET;
         threshold_ff <= pva_pkg::THRESH_RESET;
      end else begin
         damping_ff   <= damping_in;
         threshold_ff <= threshold_in;
      end
   end

   // Clamp damping at 1.0
   assign damping_eff = (damping_ff > pva_pkg::ONE_Q016) ? pva_pkg::ONE_Q016 : damping_ff;

   pva_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_vertex_delta   (req_vertex_delta),
      .req_vertex_score   (req_vertex_score),
      .req_old_update_sum (req_old_update_sum),
      .req_out_degree     (req_out_degree),
      .req_last_vertex    (req_last_vertex),
      .damping_eff        (damping_eff),
      .threshold          (threshold_ff),
      .q_status           (q_status),
      .q_push             (q_push),
      .q_entry            (q_entry)
   );

   pva_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .status     (q_status)
   );

   pva_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .damping_eff        (damping_eff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_new_score      (rsp_new_score),
      .rsp_push_value     (rsp_push_value),
      .rsp_new_update_sum (rsp_new_update_sum),
      .rsp_vertex_active  (rsp_vertex_active),
      .rsp_update_count   (rsp_update_count),
      .rsp_pass_done      (rsp_pass_done)
   );

`ifndef SYNTHESIS
   // An inactive vertex pushes nothing
   a_inactive_no_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_vertex_active |-> rsp_push_value == '0)
      else $error("inactive vertex with non-zero push value");

   // Queue cannot be both full and empty
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue status full and empty at once");

   // No word is pushed into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_push)
      else $error("push into full queue");

   // No response right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule

@@ tb/pva_update_checker.sv @@
// Checker for the PageRank vertex apply core: watches the request, response and register ports,
// predicts each response word and compares it field by field. Depends on pva_pkg.

module pva_update_checker #(
   parameter int FRAC_BITS = pva_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_command,
   input  logic [pva_pkg::DATA_W-1:0]    req_vertex_delta,
   input  logic [pva_pkg::DATA_W-1:0]    req_vertex_score,
   input  logic [pva_pkg::DATA_W-1:0]    req_old_update_sum,
   input  logic [pva_pkg::DATA_W-1:0]    req_out_degree,
   input  logic                          req_last_vertex,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [pva_pkg::DATA_W-1:0]    rsp_new_score,
   input  logic [pva_pkg::DATA_W-1:0]    rsp_push_value,
   input  logic [pva_pkg::DATA_W-1:0]    rsp_new_update_sum,
   input  logic                          rsp_vertex_active,
   input  logic [pva_pkg::DATA_W-1:0]    rsp_update_count,
   input  logic                          rsp_pass_done,
   input  logic                          csr_write_enable,
   input  logic [pva_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pva_pkg::DATA_W-1:0]    csr_write_data,
   output int                            updates_in_flight,
   output int                            mismatch_count
);

   typedef struct packed {
      logic [pva_pkg::DATA_W-1:0] score;
      logic [pva_pkg::DATA_W-1:0] push;
      logic [pva_pkg::DATA_W-1:0] next_sum;
      logic                       active;
      logic [pva_pkg::DATA_W-1:0] count;
      logic                       pass_done;
   } vertex_outcome_type;

   // Shadow copy of the registers and the per-pass activation count
   logic [pva_pkg::DAMP_W-1:0] damping_q;
   logic [pva_pkg::DATA_W-1:0] threshold_q;
   logic [pva_pkg::DATA_W-1:0] activations;

   vertex_outcome_type   expected_updates[$];
   vertex_outcome_type   oldest;
   int                   response_number;

   initial begin
      updates_in_flight = 0;
      mismatch_count    = 0;
      response_number   = 0;
   end

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] response %0d: %s", $time, response_number, what);
   endtask

   task automatic check_field(input string name, input logic [pva_pkg::DATA_W-1:0] got,
                              input logic [pva_pkg::DATA_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
   endtask

   // floor(floor(damping * x / degree) / 1.0), zero for a vertex with no out edges
   function automatic logic [pva_pkg::DATA_W-1:0] per_edge_push(
      input logic [pva_pkg::DAMP_W-1:0] damp,
      input logic [pva_pkg::DATA_W-1:0] x,
      input logic [pva_pkg::DATA_W-1:0] degree);
      logic [63:0] product;
      product = 64'(damp) * 64'(x);
      if (degree == '0)
         return '0;
      return pva_pkg::DATA_W'((product / 64'(degree)) >> pva_pkg::DAMP_FRAC);
   endfunction

   // Work out the response word for one vertex record and advance the count
   function automatic vertex_outcome_type predict_vertex_update(
      input logic                       cmd,
      input logic [pva_pkg::DATA_W-1:0] delta,
      input logic [pva_pkg::DATA_W-1:0] score,
      input logic [pva_pkg::DATA_W-1:0] old_sum,
      input logic [pva_pkg::DATA_W-1:0] degree,
      input logic                       last);
      vertex_outcome_type         outcome;
      logic [pva_pkg::DAMP_W-1:0] damp_eff;
      logic [pva_pkg::DATA_W-1:0] residual;
      logic [pva_pkg::DATA_W:0]   score_sum;

      // damping above 1.0 acts as 1.0
      damp_eff = (damping_q > pva_pkg::ONE_Q016) ? pva_pkg::ONE_Q016 : damping_q;
      residual = pva_pkg::DATA_W'(pva_pkg::ONE_Q016 - damp_eff);
      if (FRAC_BITS >= pva_pkg::DAMP_FRAC)
         residual = residual << (FRAC_BITS >= pva_pkg::DAMP_FRAC ?
                                 FRAC_BITS - pva_pkg::DAMP_FRAC : 0);
      else
         residual = residual >> (FRAC_BITS < pva_pkg::DAMP_FRAC ?
                                 pva_pkg::DAMP_FRAC - FRAC_BITS : 0);

      outcome = '0;
      outcome.pass_done = last;
      if (cmd == pva_pkg::CMD_INIT) begin
         outcome.score    = residual;
         outcome.next_sum = '0;
         outcome.push     = per_edge_push(damp_eff, residual, degree);
         outcome.active   = 1'b1;
      end else if (delta > threshold_q) begin
         score_sum        = {1'b0, score} + {1'b0, delta};
         outcome.score    = score_sum[pva_pkg::DATA_W] ? pva_pkg::COUNT_MAX
                                                       : score_sum[pva_pkg::DATA_W-1:0];
         outcome.next_sum = delta;
         outcome.push     = per_edge_push(damp_eff, delta, degree);
         outcome.active   = 1'b1;
         if (activations != pva_pkg::COUNT_MAX)
            activations++;
      end else begin
         outcome.score    = score;
         outcome.next_sum = old_sum;
         outcome.push     = '0;
         outcome.active   = 1'b0;
      end
      outcome.count = activations;

      // restart the count after the last vertex of a pass
      if (last)
         activations = '0;
      return outcome;
   endfunction

   // Compare responses first so a request taken on the same edge queues behind them
   always @(posedge clock) begin
      if (reset) begin
         damping_q   = pva_pkg::DAMP_RESET;
         threshold_q = pva_pkg::THRESH_RESET;
         activations = '0;
         expected_updates.delete();
         updates_in_flight = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_updates.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else begin
               oldest = expected_updates.pop_front();
               updates_in_flight--;
               check_field("new_score", rsp_new_score, oldest.score);
               check_field("push_value", rsp_push_value, oldest.push);
               check_field("new_update_sum", rsp_new_update_sum, oldest.next_sum);
               check_field("vertex_active", pva_pkg::DATA_W'(rsp_vertex_active),
                           pva_pkg::DATA_W'(oldest.active));
               check_field("active count", rsp_update_count, oldest.count);
               check_field("pass_done", pva_pkg::DATA_W'(rsp_pass_done),
                           pva_pkg::DATA_W'(oldest.pass_done));
            end
            response_number++;
         end
         if (req_valid && !req_stall) begin
            expected_updates.push_back(predict_vertex_update(req_command, req_vertex_delta,
               req_vertex_score, req_old_update_sum, req_out_degree, req_last_vertex));
            updates_in_flight++;
         end
         if (csr_write_enable) begin
            case (csr_index)
               pva_pkg::REG_DAMPING: begin
                  damping_q = csr_write_data[pva_pkg::DAMP_W-1:0];
               end
               pva_pkg::REG_THRESHOLD: begin
                  threshold_q = csr_write_data;
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

@@ tb/pagerank_vertex_apply_core_tb.sv @@
// Testbench top for the PageRank vertex apply core: clock, reset, register phases, directed
// and random vertex words, random stalls. Depends on pva_pkg and pva_update_checker.

module pagerank_vertex_apply_core_tb;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int WORDS_PER_PHASE = 205;
   localparam int PHASE_COUNT     = 7;
   localparam int SETTLE_CYCLES   = 40;

   typedef struct packed {
      logic                       command;
      logic [pva_pkg::DATA_W-1:0] delta;
      logic [pva_pkg::DATA_W-1:0] score;
      logic [pva_pkg::DATA_W-1:0] old_sum;
      logic [pva_pkg::DATA_W-1:0] degree;
      logic                       last;
   } vertex_word_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_command;
   logic [pva_pkg::DATA_W-1:0]    req_vertex_delta;
   logic [pva_pkg::DATA_W-1:0]    req_vertex_score;
   logic [pva_pkg::DATA_W-1:0]    req_old_update_sum;
   logic [pva_pkg::DATA_W-1:0]    req_out_degree;
   logic                          req_last_vertex;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [pva_pkg::DATA_W-1:0]    rsp_new_score;
   logic [pva_pkg::DATA_W-1:0]    rsp_push_value;
   logic [pva_pkg::DATA_W-1:0]    rsp_new_update_sum;
   logic                          rsp_vertex_active;
   logic [pva_pkg::DATA_W-1:0]    rsp_update_count;
   logic                          rsp_pass_done;
   logic                          csr_write_enable;
   logic [pva_pkg::CSR_IDX_W-1:0] csr_index;
   logic [pva_pkg::DATA_W-1:0]    csr_write_data;

   int                            updates_in_flight;
   int                            mismatch_count;
   int                            cycle_count;
   int                            no_gap_left;
   logic [pva_pkg::DATA_W-1:0]    thresh_setting;

   pagerank_vertex_apply_core dut (.*);

   pva_update_checker checker_inst (.*);

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Idle length: mostly short, a few long
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85)
         return $urandom_range(1, 3);
      if (pick < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Gap before the next request word, with occasional back-to-back stretches
   function automatic int next_gap();
      if (no_gap_left > 0) begin
         no_gap_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         no_gap_left = $urandom_range(20, 60);
         return 0;
      end
      if ($urandom_range(0, 99) < 55)
         return 0;
      return idle_len();
   endfunction

   function automatic vertex_word_type make_word(input logic cmd,
                                                 input logic [pva_pkg::DATA_W-1:0] delta,
                                                 input logic [pva_pkg::DATA_W-1:0] score,
                                                 input logic [pva_pkg::DATA_W-1:0] sum,
                                                 input logic [pva_pkg::DATA_W-1:0] degree,
                                                 input logic last);
      vertex_word_type w;
      w.command = cmd;
      w.delta   = delta;
      w.score   = score;
      w.old_sum = sum;
      w.degree  = degree;
      w.last    = last;
      return w;
   endfunction

   // Random vertex record, with some deltas clustered around the current threshold
   function automatic vertex_word_type random_vertex();
      vertex_word_type w;
      longint          near;
      w.command = ($urandom_range(0, 99) < 15) ? pva_pkg::CMD_INIT : pva_pkg::CMD_APPLY;
      w.old_sum = $urandom;
      w.last    = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 5))
         0: w.delta = $urandom;
         1: begin
            near = longint'(thresh_setting) + longint'($urandom_range(0, 6)) - 3;
            if (near < 0)
               near = 0;
            if (near > longint'(pva_pkg::COUNT_MAX))
               near = longint'(pva_pkg::COUNT_MAX);
            w.delta = pva_pkg::DATA_W'(near);
         end
         2: w.delta = $urandom_range(0, 255);
         3: w.delta = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
         default: w.delta = $urandom_range(0, 32'h0004_0000);
      endcase
      case ($urandom_range(0, 19))
         0, 1, 2: w.score = pva_pkg::COUNT_MAX - $urandom_range(0, 32'h0010_0000);
         3, 4, 5: w.score = $urandom_range(0, 32'h0002_0000);
         default: w.score = $urandom;
      endcase
      case ($urandom_range(0, 9))
         0: w.degree = '0;
         1, 2, 3, 4: w.degree = $urandom_range(1, 16);
         5, 6: w.degree = $urandom_range(17, 1000);
         7, 8: w.degree = $urandom;
         default: w.degree = pva_pkg::COUNT_MAX - $urandom_range(0, 3);
      endcase
      return w;
   endfunction

   // Drive one request word at the falling edge and hold it until accepted
   task automatic send_word(input vertex_word_type w);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command        <= w.command;
      req_vertex_delta   <= w.delta;
      req_vertex_score   <= w.score;
      req_old_update_sum <= w.old_sum;
      req_out_degree     <= w.degree;
      req_last_vertex    <= w.last;
      req_valid          <= 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected response word has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (updates_in_flight != 0)
         @(negedge clock);
   endtask

   // Write damping then threshold on consecutive edges while the core is idle
   task automatic set_regs(input logic [pva_pkg::DATA_W-1:0] damp,
                           input logic [pva_pkg::DATA_W-1:0] thresh);
      csr_write_enable <= 1'b1;
      csr_index        <= pva_pkg::REG_DAMPING;
      csr_write_data   <= damp;
      @(negedge clock);
      csr_index        <= pva_pkg::REG_THRESHOLD;
      csr_write_data   <= thresh;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      thresh_setting = thresh;
   endtask

   // Directed words under the reset register values (threshold 7)
   task automatic run_directed();
      send_word(make_word(pva_pkg::CMD_INIT, 32'd5, 32'd9, 32'd3, 32'd0, 1'b0));
      send_word(make_word(pva_pkg::CMD_INIT, '0, '0, '0, 32'd1, 1'b0));
      send_word(make_word(pva_pkg::CMD_INIT, '1, '1, '1, '1, 1'b0));
      send_word(make_word(pva_pkg::CMD_APPLY, 32'd8, '0, 32'd4, 32'd1, 1'b0));
      send_word(make_word(pva_pkg::CMD_APPLY, 32'd7, 32'd100, '1, 32'd5, 1'b0));
      send_word(make_word(pva_pkg::CMD_APPLY, '0, '1, '0, '0, 1'b0));
      send_word(make_word(pva_pkg::CMD_APPLY, '1, '1, 32'h5555_AAAA, '0, 1'b0));
      send_word(make_word(pva_pkg::CMD_APPLY, '1, '0, '0, 32'd1, 1'b0));
      send_word(make_word(pva_pkg::CMD_APPLY, 32'h0001_0000, 32'h7FFF_FFFF,
                          32'd1, 32'd3, 1'b0));
      send_word(make_word(pva_pkg::CMD_APPLY, 32'h8000_0000, 32'h8000_0000,
                          32'd2, 32'd2, 1'b0));
      send_word(make_word(pva_pkg::CMD_APPLY, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'd2, 32'd7, 1'b0));
      send_word(make_word(pva_pkg::CMD_APPLY, 32'd100, 32'd1, 32'd1, 32'd2, 1'b1));
      send_word(make_word(pva_pkg::CMD_APPLY, 32'd9, 32'd1, 32'd1, 32'd1, 1'b0));
      send_word(make_word(pva_pkg::CMD_INIT, 32'd50, 32'd1, 32'd1, 32'd4, 1'b1));
      send_word(make_word(pva_pkg::CMD_APPLY, 32'd6, 32'd77, 32'hAAAA_5555, 32'd3, 1'b1));
      send_word(make_word(pva_pkg::CMD_APPLY, 32'h1234_5678, 32'd0, 32'd0, '1, 1'b0));
      send_word(make_word(pva_pkg::CMD_APPLY, 32'hFFFF_FFF0, 32'd12, 32'd0,
                          32'h0001_0000, 1'b0));
      send_word(make_word(pva_pkg::CMD_INIT, 32'd0, 32'd0, 32'd0, 32'd3, 1'b1));
   endtask

   // Response side stalls: random runs, a few long, with calm stretches
   initial begin : rsp_backpressure
      int hold_left;
      int pick;
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               rsp_stall <= 1'b0;
               hold_left = $urandom_range(30, 80);
            end else if (pick < 45) begin
               rsp_stall <= 1'b1;
               hold_left = idle_len() - 1;
            end else begin
               rsp_stall <= 1'b0;
               hold_left = $urandom_range(0, 5);
            end
         end
      end
   end

   // End the run if it hangs
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Reset, then one phase per register setting, then the verdict
   initial begin : stimulus
      logic [pva_pkg::DATA_W-1:0] damp_value;
      logic [pva_pkg::DATA_W-1:0] thresh_value;

      reset              = 1'b1;
      req_valid          = 1'b0;
      req_command        = pva_pkg::CMD_APPLY;
      req_vertex_delta   = '0;
      req_vertex_score   = '0;
      req_old_update_sum = '0;
      req_out_degree     = '0;
      req_last_vertex    = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = pva_pkg::REG_DAMPING;
      csr_write_data     = '0;
      thresh_setting     = pva_pkg::THRESH_RESET;
      no_gap_left        = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 0) begin
            run_directed();
         end else begin
            case (phase)
               1: begin
                  damp_value   = '0;
                  thresh_value = '0;
               end
               2: begin
                  damp_value   = pva_pkg::DATA_W'(pva_pkg::ONE_Q016);
                  thresh_value = '1;
               end
               3: begin
                  // upper data bits are dropped; the 17-bit value is above 1.0
                  damp_value   = '1;
                  thresh_value = 32'h0001_0000;
               end
               4: begin
                  damp_value   = 32'd1;
                  thresh_value = $urandom;
               end
               5: begin
                  damp_value   = $urandom_range(0, 17'h1FFFF);
                  thresh_value = $urandom_range(0, 32'h0002_0000);
               end
               default: begin
                  damp_value   = pva_pkg::DATA_W'(pva_pkg::DAMP_RESET);
                  thresh_value = $urandom_range(0, 255);
               end
            endcase
            set_regs(damp_value, thresh_value);
         end
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            send_word(random_vertex());
            // hold off the sender until the core has emptied
            if (phase == 1 && n == WORDS_PER_PHASE / 2)
               drain();
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
